/* hdl/complex_arithmetic_unit_defines.svh */
// assertion helpers for the complex arithmetic unit checker
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// antecedent implies consequent, sampled on clk, off during reset
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// expression holds at every sampled edge out of reset
`define CAU_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

/* hdl/cau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int SUM_WIDTH  = 2 * DATA_WIDTH + 2;
    localparam int REM_WIDTH  = 3 * DATA_WIDTH;
    // input register, product, sum, magnitude, range check, one stage per bit, output
    localparam int LATENCY    = DATA_WIDTH + 6;

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_MOD  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]                   operation;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
    } request_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_real;
        logic signed [DATA_WIDTH-1:0] res_imag;
        status_t                      status;
    } result_t;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic neg_re;
        logic neg_im;
        logic dz;
        logic ovf_re;
        logic ovf_im;
    } ctrl_t;

endpackage
`default_nettype wire

/* hdl/cau_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module cau_front
    import cau_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire request_t         request,
    output ctrl_t                 ctrl,
    output logic [REM_WIDTH-1:0]  rem_re,
    output logic [REM_WIDTH-1:0]  rem_im,
    output logic [PROD_WIDTH-1:0] den
);

    // stage a: input word
    logic     a_vld_reg;
    request_t a_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_req_reg <= request;
        end
    end

    // stage b: products and short sums
    op_t                          a_op;
    logic signed [DATA_WIDTH-1:0] sq_x;
    logic signed [DATA_WIDTH-1:0] sq_y;
    ctrl_t                        b_ctrl_next;
    ctrl_t                        b_ctrl_reg;
    logic signed [PROD_WIDTH-1:0] b_p0_next, b_p1_next, b_p2_next;
    logic signed [PROD_WIDTH-1:0] b_p3_next, b_p4_next, b_p5_next;
    logic signed [PROD_WIDTH-1:0] b_p0_reg, b_p1_reg, b_p2_reg;
    logic signed [PROD_WIDTH-1:0] b_p3_reg, b_p4_reg, b_p5_reg;
    logic signed [DATA_WIDTH:0]   b_s_re_next, b_s_im_next;
    logic signed [DATA_WIDTH:0]   b_s_re_reg, b_s_im_reg;

    assign a_op = op_t'(a_req_reg.operation);

    // modulus squares a through the multipliers that square b for divide
    assign sq_x = (a_op == OP_MOD) ? a_req_reg.a_real : a_req_reg.b_real;
    assign sq_y = (a_op == OP_MOD) ? a_req_reg.a_imag : a_req_reg.b_imag;

    assign b_p0_next = a_req_reg.a_real * a_req_reg.b_real;
    assign b_p1_next = a_req_reg.a_imag * a_req_reg.b_imag;
    assign b_p2_next = a_req_reg.a_real * a_req_reg.b_imag;
    assign b_p3_next = a_req_reg.a_imag * a_req_reg.b_real;
    assign b_p4_next = sq_x * sq_x;
    assign b_p5_next = sq_y * sq_y;

    always_comb
    begin
        b_ctrl_next       = '0;
        b_ctrl_next.valid = a_vld_reg;
        b_ctrl_next.op    = a_op;
        unique case (a_op)
            OP_ADD:
            begin
                b_s_re_next = (DATA_WIDTH+1)'(a_req_reg.a_real) + (DATA_WIDTH+1)'(a_req_reg.b_real);
                b_s_im_next = (DATA_WIDTH+1)'(a_req_reg.a_imag) + (DATA_WIDTH+1)'(a_req_reg.b_imag);
            end
            OP_SUB:
            begin
                b_s_re_next = (DATA_WIDTH+1)'(a_req_reg.a_real) - (DATA_WIDTH+1)'(a_req_reg.b_real);
                b_s_im_next = (DATA_WIDTH+1)'(a_req_reg.a_imag) - (DATA_WIDTH+1)'(a_req_reg.b_imag);
            end
            OP_CONJ:
            begin
                b_s_re_next = (DATA_WIDTH+1)'(a_req_reg.a_real);
                b_s_im_next = (DATA_WIDTH+1)'(0) - (DATA_WIDTH+1)'(a_req_reg.a_imag);
            end
            default:
            begin
                b_s_re_next = '0;
                b_s_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctrl_reg <= '0;
        end
        else
        begin
            b_ctrl_reg <= b_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_p0_reg   <= b_p0_next;
        b_p1_reg   <= b_p1_next;
        b_p2_reg   <= b_p2_next;
        b_p3_reg   <= b_p3_next;
        b_p4_reg   <= b_p4_next;
        b_p5_reg   <= b_p5_next;
        b_s_re_reg <= b_s_re_next;
        b_s_im_reg <= b_s_im_next;
    end

    // stage c: exact signed parts and squared magnitude
    ctrl_t                        c_ctrl_reg;
    logic signed [SUM_WIDTH-1:0]  c_v_re_next, c_v_im_next;
    logic signed [SUM_WIDTH-1:0]  c_v_re_reg, c_v_im_reg;
    logic [PROD_WIDTH-1:0]        c_den_next;
    logic [PROD_WIDTH-1:0]        c_den_reg;

    assign c_den_next = $unsigned(b_p4_reg) + $unsigned(b_p5_reg);

    always_comb
    begin
        unique case (b_ctrl_reg.op)
            OP_ADD, OP_SUB, OP_CONJ:
            begin
                c_v_re_next = SUM_WIDTH'(b_s_re_reg);
                c_v_im_next = SUM_WIDTH'(b_s_im_reg);
            end
            OP_MUL:
            begin
                c_v_re_next = SUM_WIDTH'(b_p0_reg) - SUM_WIDTH'(b_p1_reg);
                c_v_im_next = SUM_WIDTH'(b_p2_reg) + SUM_WIDTH'(b_p3_reg);
            end
            OP_DIV:
            begin
                // numerator of a * conj(b)
                c_v_re_next = SUM_WIDTH'(b_p0_reg) + SUM_WIDTH'(b_p1_reg);
                c_v_im_next = SUM_WIDTH'(b_p3_reg) - SUM_WIDTH'(b_p2_reg);
            end
            default:
            begin
                c_v_re_next = '0;
                c_v_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctrl_reg <= '0;
        end
        else
        begin
            c_ctrl_reg <= b_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_v_re_reg <= c_v_re_next;
        c_v_im_reg <= c_v_im_next;
        c_den_reg  <= c_den_next;
    end

    // stage d: sign and magnitude, scaled for the operation
    logic                  sgn_re, sgn_im;
    logic [SUM_WIDTH-1:0]  mag_re, mag_im;
    ctrl_t                 d_ctrl_next;
    ctrl_t                 d_ctrl_reg;
    logic [REM_WIDTH-1:0]  d_rem_re_next, d_rem_im_next;
    logic [REM_WIDTH-1:0]  d_rem_re_reg, d_rem_im_reg;
    logic [PROD_WIDTH-1:0] d_den_reg;

    assign sgn_re = c_v_re_reg[SUM_WIDTH-1];
    assign sgn_im = c_v_im_reg[SUM_WIDTH-1];
    assign mag_re = sgn_re ? SUM_WIDTH'(0) - $unsigned(c_v_re_reg) : $unsigned(c_v_re_reg);
    assign mag_im = sgn_im ? SUM_WIDTH'(0) - $unsigned(c_v_im_reg) : $unsigned(c_v_im_reg);

    always_comb
    begin
        d_ctrl_next        = c_ctrl_reg;
        d_ctrl_next.neg_re = sgn_re;
        d_ctrl_next.neg_im = sgn_im;
        d_ctrl_next.dz     = (c_ctrl_reg.op == OP_DIV) && (c_den_reg == '0);
        unique case (c_ctrl_reg.op)
            OP_ADD, OP_SUB, OP_CONJ:
            begin
                d_rem_re_next = REM_WIDTH'(mag_re);
                d_rem_im_next = REM_WIDTH'(mag_im);
            end
            OP_MUL:
            begin
                // truncate toward zero on the magnitude
                d_rem_re_next = REM_WIDTH'(mag_re >> FRAC_BITS);
                d_rem_im_next = REM_WIDTH'(mag_im >> FRAC_BITS);
            end
            OP_DIV:
            begin
                d_rem_re_next = REM_WIDTH'(mag_re) << FRAC_BITS;
                d_rem_im_next = REM_WIDTH'(mag_im) << FRAC_BITS;
            end
            OP_MOD:
            begin
                d_rem_re_next      = REM_WIDTH'(c_den_reg);
                d_rem_im_next      = '0;
                d_ctrl_next.neg_re = 1'b0;
                d_ctrl_next.neg_im = 1'b0;
            end
            default:
            begin
                d_rem_re_next      = '0;
                d_rem_im_next      = '0;
                d_ctrl_next.neg_re = 1'b0;
                d_ctrl_next.neg_im = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_ctrl_reg <= '0;
        end
        else
        begin
            d_ctrl_reg <= d_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_rem_re_reg <= d_rem_re_next;
        d_rem_im_reg <= d_rem_im_next;
        d_den_reg    <= c_den_reg;
    end

    // stage e: quotient must fit in DATA_WIDTH bits or it saturates
    logic [REM_WIDTH-1:0]  den_top;
    ctrl_t                 e_ctrl_next;
    ctrl_t                 e_ctrl_reg;
    logic [REM_WIDTH-1:0]  e_rem_re_reg, e_rem_im_reg;
    logic [PROD_WIDTH-1:0] e_den_reg;

    assign den_top = {d_den_reg, {DATA_WIDTH{1'b0}}};

    always_comb
    begin
        e_ctrl_next        = d_ctrl_reg;
        e_ctrl_next.ovf_re = (d_ctrl_reg.op == OP_DIV) && (d_rem_re_reg >= den_top);
        e_ctrl_next.ovf_im = (d_ctrl_reg.op == OP_DIV) && (d_rem_im_reg >= den_top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_ctrl_reg <= '0;
        end
        else
        begin
            e_ctrl_reg <= e_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_rem_re_reg <= d_rem_re_reg;
        e_rem_im_reg <= d_rem_im_reg;
        e_den_reg    <= d_den_reg;
    end

    assign ctrl   = e_ctrl_reg;
    assign rem_re = e_rem_re_reg;
    assign rem_im = e_rem_im_reg;
    assign den    = e_den_reg;

endmodule
`default_nettype wire

/* hdl/cau_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module cau_step
    import cau_pkg::*;
#(
    parameter int STEP = DATA_WIDTH - 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_t                 ctrl_in,
    input  wire logic [REM_WIDTH-1:0]  rem_re_in,
    input  wire logic [REM_WIDTH-1:0]  rem_im_in,
    input  wire logic [PROD_WIDTH-1:0] den_in,
    input  wire logic [DATA_WIDTH-1:0] q_re_in,
    input  wire logic [DATA_WIDTH-1:0] q_im_in,
    output ctrl_t                      ctrl_out,
    output logic [REM_WIDTH-1:0]       rem_re_out,
    output logic [REM_WIDTH-1:0]       rem_im_out,
    output logic [PROD_WIDTH-1:0]      den_out,
    output logic [DATA_WIDTH-1:0]      q_re_out,
    output logic [DATA_WIDTH-1:0]      q_im_out
);

    // one quotient bit for divide, or one root bit for modulus, per stage
    logic                  is_div, is_mod;
    logic [REM_WIDTH-1:0]  trial_div, trial_sq, trial_re;
    logic                  take_re, take_im;
    logic [REM_WIDTH-1:0]  rem_re_next, rem_im_next;
    logic [DATA_WIDTH-1:0] q_re_next, q_im_next;
    ctrl_t                 ctrl_reg;
    logic [REM_WIDTH-1:0]  rem_re_reg, rem_im_reg;
    logic [PROD_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] q_re_reg, q_im_reg;

    assign is_div = (ctrl_in.op == OP_DIV);
    assign is_mod = (ctrl_in.op == OP_MOD);

    assign trial_div = REM_WIDTH'(den_in) << STEP;
    // (2 * root + 2^step) * 2^step, root holds only higher bits so or is add
    assign trial_sq  = (REM_WIDTH'(q_re_in) << (STEP + 1)) | (REM_WIDTH'(1) << (2 * STEP));
    assign trial_re  = is_mod ? trial_sq : trial_div;

    assign take_re = (is_div || is_mod) && (rem_re_in >= trial_re);
    assign take_im = is_div && (rem_im_in >= trial_div);

    assign rem_re_next = take_re ? rem_re_in - trial_re : rem_re_in;
    assign rem_im_next = take_im ? rem_im_in - trial_div : rem_im_in;
    assign q_re_next   = q_re_in | (DATA_WIDTH'(take_re) << STEP);
    assign q_im_next   = q_im_in | (DATA_WIDTH'(take_im) << STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_re_reg <= rem_re_next;
        rem_im_reg <= rem_im_next;
        den_reg    <= den_in;
        q_re_reg   <= q_re_next;
        q_im_reg   <= q_im_next;
    end

    assign ctrl_out   = ctrl_reg;
    assign rem_re_out = rem_re_reg;
    assign rem_im_out = rem_im_reg;
    assign den_out    = den_reg;
    assign q_re_out   = q_re_reg;
    assign q_im_out   = q_im_reg;

endmodule
`default_nettype wire

/* hdl/cau_sat.sv */
`timescale 1ns / 1ps
`default_nettype none
module cau_sat
    import cau_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_t                 ctrl_in,
    input  wire logic [REM_WIDTH-1:0]  rem_re_in,
    input  wire logic [REM_WIDTH-1:0]  rem_im_in,
    input  wire logic [DATA_WIDTH-1:0] q_re_in,
    input  wire logic [DATA_WIDTH-1:0] q_im_in,
    output logic                       done,
    output result_t                    result
);

    // returns {saturated, value}
    function automatic logic [DATA_WIDTH:0] clamp_lane(
        input logic                 neg,
        input logic                 ovf,
        input logic [REM_WIDTH-1:0] mag
    );
        logic [REM_WIDTH-1:0]  lim;
        logic                  over;
        logic [DATA_WIDTH-1:0] val;
        lim  = REM_WIDTH'(MAX_POS) + REM_WIDTH'(neg);
        over = ovf || (mag > lim);
        if (over)
        begin
            val = neg ? MIN_NEG : MAX_POS;
        end
        else
        begin
            val = neg ? DATA_WIDTH'(0) - mag[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
        end
        return {over, val};
    endfunction

    logic                  from_q;
    logic [REM_WIDTH-1:0]  mag_re, mag_im;
    logic [DATA_WIDTH:0]   lane_re, lane_im;
    result_t               result_next;
    logic                  done_reg;
    result_t               result_reg;

    assign from_q = (ctrl_in.op == OP_DIV) || (ctrl_in.op == OP_MOD);
    assign mag_re = from_q ? REM_WIDTH'(q_re_in) : rem_re_in;
    assign mag_im = from_q ? REM_WIDTH'(q_im_in) : rem_im_in;

    assign lane_re = clamp_lane(ctrl_in.neg_re, ctrl_in.ovf_re, mag_re);
    assign lane_im = clamp_lane(ctrl_in.neg_im, ctrl_in.ovf_im, mag_im);

    always_comb
    begin
        priority if (ctrl_in.dz)
        begin
            result_next.res_real = '0;
            result_next.res_imag = '0;
            result_next.status   = ST_DIVZ;
        end
        else
        begin
            result_next.res_real = $signed(lane_re[DATA_WIDTH-1:0]);
            result_next.res_imag = $signed(lane_im[DATA_WIDTH-1:0]);
            result_next.status   = (lane_re[DATA_WIDTH] || lane_im[DATA_WIDTH]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* hdl/complex_arithmetic_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Complex ALU on signed Q16.16 parts. A word is taken on every clock edge
// where start is high; busy never rises, so a new word may follow every
// cycle. Each word's result shows on result with done high for exactly one
// cycle, in order, through the same pipeline for every operation alike. The
// pipeline depth is set by the divide and square-root chain, which resolves
// one quotient or root bit per pipeline stage, 32 stages in all, behind
// five stages of input capture, multiply, sum, magnitude and range check,
// and one output stage that saturates.
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          done,
    output result_t       result
);

    logic accept;

    wire ctrl_t                 chain_ctrl   [0:DATA_WIDTH];
    wire logic [REM_WIDTH-1:0]  chain_rem_re [0:DATA_WIDTH];
    wire logic [REM_WIDTH-1:0]  chain_rem_im [0:DATA_WIDTH];
    wire logic [PROD_WIDTH-1:0] chain_den    [0:DATA_WIDTH];
    wire logic [DATA_WIDTH-1:0] chain_q_re   [0:DATA_WIDTH];
    wire logic [DATA_WIDTH-1:0] chain_q_im   [0:DATA_WIDTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cau_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .ctrl    (chain_ctrl[0]),
        .rem_re  (chain_rem_re[0]),
        .rem_im  (chain_rem_im[0]),
        .den     (chain_den[0])
    );

    assign chain_q_re[0] = '0;
    assign chain_q_im[0] = '0;

    // most significant bit first
    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_step
        cau_step #(
            .STEP (DATA_WIDTH - 1 - i)
        ) u_step
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl_in    (chain_ctrl[i]),
            .rem_re_in  (chain_rem_re[i]),
            .rem_im_in  (chain_rem_im[i]),
            .den_in     (chain_den[i]),
            .q_re_in    (chain_q_re[i]),
            .q_im_in    (chain_q_im[i]),
            .ctrl_out   (chain_ctrl[i+1]),
            .rem_re_out (chain_rem_re[i+1]),
            .rem_im_out (chain_rem_im[i+1]),
            .den_out    (chain_den[i+1]),
            .q_re_out   (chain_q_re[i+1]),
            .q_im_out   (chain_q_im[i+1])
        );
    end

    cau_sat u_sat
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_in   (chain_ctrl[DATA_WIDTH]),
        .rem_re_in (chain_rem_re[DATA_WIDTH]),
        .rem_im_in (chain_rem_im[DATA_WIDTH]),
        .q_re_in   (chain_q_re[DATA_WIDTH]),
        .q_im_in   (chain_q_im[DATA_WIDTH]),
        .done      (done),
        .result    (result)
    );

endmodule
`default_nettype wire

/* hdl/cau_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arithmetic_unit_defines.svh"
module cau_checker
    import cau_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire request_t request,
    input wire logic     done,
    input wire result_t  result
);

    `CAU_ASSERT_IMP(a_fixed_latency, start && !busy, ##LATENCY done, "word lost in pipeline")
    `CAU_ASSERT_IMP(a_no_extra, done, $past(start && !busy, LATENCY), "result without a word")
    `CAU_ASSERT_IMP(a_divz_cause, done && result.status == ST_DIVZ, $past(request.operation, LATENCY) == OP_DIV && $past(request.b_real, LATENCY) == 0 && $past(request.b_imag, LATENCY) == 0, "divide by zero status without zero divisor")
    `CAU_ASSERT_IMP(a_mod_imag, done && $past(request.operation, LATENCY) == OP_MOD, result.res_imag == 0 && result.status != ST_DIVZ, "modulus with nonzero imaginary part")
    `CAU_ASSERT_ALWAYS(a_divz_zero, !(done && result.status == ST_DIVZ) || (result.res_real == 0 && result.res_imag == 0), "divide by zero result not zero")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import cau_pkg::*;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam int         IDLE_PCT = 31;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    result_t  pending_results[$];
    int       errors;
    bit       idle_enable;

    complex_arithmetic_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // clamp an exact value into the part range, flagging saturation
    function automatic logic [DATA_WIDTH-1:0] clamp_part(input logic signed [129:0] v,
                                                         inout bit sat);
        logic signed [129:0] hi_lim;
        logic signed [129:0] lo_lim;
        hi_lim = $signed(MAX_POS);
        lo_lim = $signed(MIN_NEG);
        if (v > hi_lim)
        begin
            sat = 1'b1;
            return MAX_POS;
        end
        if (v < lo_lim)
        begin
            sat = 1'b1;
            return MIN_NEG;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [65:0] s);
        logic [65:0] root;
        logic [65:0] cand;
        root = '0;
        for (int i = 32; i >= 0; i--)
        begin
            cand = root | (66'd1 << i);
            if (cand * cand <= s)
                root = cand;
        end
        return root[63:0];
    endfunction

    function automatic result_t complex_alu_predict(input request_t req);
        logic signed [129:0] ar, ai, br, bi, re, im, den;
        result_t r;
        bit sat;
        ar = req.a_real;
        ai = req.a_imag;
        br = req.b_real;
        bi = req.b_imag;
        re = '0;
        im = '0;
        sat = 1'b0;
        r.status = ST_OK;
        case (req.operation)
            OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL:
            begin
                // signed divide truncates toward zero, as the hardware does
                re = (ar * br - ai * bi) / 130'sd65536;
                im = (ar * bi + ai * br) / 130'sd65536;
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.status = ST_DIVZ;
                else
                begin
                    re = ((ar * br + ai * bi) * 130'sd65536) / den;
                    im = ((ai * br - ar * bi) * 130'sd65536) / den;
                end
            end
            OP_CONJ:
            begin
                re = ar;
                im = -ai;
            end
            OP_MOD:
                re = $signed({66'd0, floor_sqrt(66'(ar * ar + ai * ai))});
            default: ;
        endcase
        r.res_real = clamp_part(re, sat);
        r.res_imag = clamp_part(im, sat);
        if (r.status == ST_OK && sat)
            r.status = ST_SAT;
        return r;
    endfunction

    // drive one word and wait until it is taken; start is left high
    task automatic send_word(input request_t req);
        @(negedge clk);
        start   = 1'b1;
        request = req;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(complex_alu_predict(req));
    endtask

    // each pass of the loop leaves one cycle with start low
    task automatic maybe_idle();
        while (idle_enable && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            start   = 1'b0;
            request = request_t'({3'($urandom), $urandom, $urandom, $urandom, $urandom});
        end
    endtask

    task automatic send_op(input logic [2:0] op, input logic [31:0] a_re, input logic [31:0] a_im,
                           input logic [31:0] b_re, input logic [31:0] b_im);
        request_t req;
        req.operation = op;
        req.a_real    = a_re;
        req.a_imag    = a_im;
        req.b_real    = b_re;
        req.b_imag    = b_im;
        send_word(req);
        maybe_idle();
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(9))
            0:       return MAX_POS;
            1:       return MIN_NEG;
            2:       return 32'd0;
            3, 4:    return 32'($signed($urandom_range(32'h1fffff)) - 32'sh100000);
            5:       return 32'($signed($urandom_range(32'h1ffff)) - 32'sh10000);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                if (result.res_real !== want.res_real)
                begin
                    $display("%0t: res_real expected %h actual %h", $time,
                             want.res_real, result.res_real);
                    errors++;
                end
                if (result.res_imag !== want.res_imag)
                begin
                    $display("%0t: res_imag expected %h actual %h", $time,
                             want.res_imag, result.res_imag);
                    errors++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, result.status);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_op(OP_ADD, MAX_POS, MIN_NEG, MAX_POS, MIN_NEG);
        send_op(OP_ADD, 32'h0001_8000, 32'hffff_0000, 32'h0000_8000, 32'h0002_0000);
        send_op(OP_SUB, MIN_NEG, MAX_POS, MAX_POS, MIN_NEG);
        send_op(OP_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0);
        send_op(OP_MUL, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG);
        send_op(OP_MUL, MAX_POS, MAX_POS, MAX_POS, MIN_NEG);
        send_op(OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'hffff_0000, 32'h0003_0000);
        send_op(OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0);
        send_op(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_op(OP_DIV, MAX_POS, MIN_NEG, 32'h0, 32'h0);
        send_op(OP_DIV, MAX_POS, MAX_POS, 32'h0000_0001, 32'h0);
        send_op(OP_DIV, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG);
        send_op(OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'hffff_0000);
        send_op(OP_DIV, 32'hffff_ffff, 32'h0, MAX_POS, 32'h0);
        send_op(OP_CONJ, MAX_POS, MIN_NEG, MAX_POS, MIN_NEG);
        send_op(OP_CONJ, MIN_NEG, MAX_POS, 32'h0, 32'h0);
        send_op(OP_MOD, MIN_NEG, MIN_NEG, 32'h0, 32'h0);
        send_op(OP_MOD, MAX_POS, 32'h0, 32'h0, 32'h0);
        send_op(OP_MOD, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0);
        send_op(OP_MOD, 32'h0, 32'h0, MAX_POS, MIN_NEG);
        send_op(OP_RSVD6, MAX_POS, MIN_NEG, MAX_POS, MIN_NEG);
        send_op(OP_RSVD7, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 32'h1);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
            send_op(3'($urandom_range(7)), rand_part(), rand_part(), rand_part(), rand_part());
    endtask

    // hold off until the pipeline has emptied, then continue
    task automatic test_drain();
        @(negedge clk);
        start = 1'b0;
        wait (pending_results.size() == 0);
        test_random(40);
    endtask

    task automatic test_burst();
        idle_enable = 1'b0;
        test_random(300);
        idle_enable = 1'b1;
    endtask

    initial
    begin
        errors      = 0;
        idle_enable = 1'b1;
        start       = 1'b0;
        request     = '0;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(500);
        test_drain();
        test_burst();
        test_random(450);

        @(negedge clk);
        start = 1'b0;
        wait (pending_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
